>>> design/ihds_pkg.sv
// ----------------------------------------------------------------------------
// ihds_pkg
// shared types and constants of the image header dimension parser
// ----------------------------------------------------------------------------
`default_nettype none

package ihds_pkg;

   // byte position counter, saturating at all ones
   localparam int POSITION_BITS = 32;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // stored file header
   localparam int HDR_DEPTH = 30;

   // result field widths
   localparam int KIND_BITS = 3;
   localparam int DIM_BITS  = 32;

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [KIND_BITS-1:0]     kind_type;
   typedef logic [DIM_BITS-1:0]      dim_type;

   // format codes
   localparam kind_type KIND_NONE = 3'd0;
   localparam kind_type KIND_PNG  = 3'd1;
   localparam kind_type KIND_VP8X = 3'd2;
   localparam kind_type KIND_VP8  = 3'd3;
   localparam kind_type KIND_VP8L = 3'd4;
   localparam kind_type KIND_JPEG = 3'd5;

   // signatures and chunk tags, first byte in the top bits
   localparam logic [63:0] SIG_PNG  = 64'h89504E470D0A1A0A;
   localparam logic [31:0] TAG_IHDR = 32'h49484452;
   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WEBP = 32'h57454250;
   localparam logic [31:0] TAG_VP8X = 32'h56503858;
   localparam logic [31:0] TAG_VP8S = 32'h56503820;
   localparam logic [31:0] TAG_VP8L = 32'h5650384C;

   // jpeg markers
   localparam logic [7:0] JPEG_FF   = 8'hFF;
   localparam logic [7:0] JPEG_SOI  = 8'hD8;
   localparam logic [7:0] JPEG_TEM  = 8'h01;
   localparam logic [7:0] JPEG_RST0 = 8'hD0;
   localparam logic [7:0] JPEG_RST7 = 8'hD7;
   localparam logic [7:0] JPEG_DHT  = 8'hC4;
   localparam logic [7:0] JPEG_JPG  = 8'hC8;
   localparam logic [7:0] JPEG_DAC  = 8'hCC;

   localparam logic [13:0] DIM14_MASK = 14'h3FFF;

   // one byte handed to the decoders
   typedef struct packed {
      logic    en;      // byte is examined
      logic    rearm;   // last byte of the file, back to the start state
      pos_type pos;
      logic [7:0] data;
   } step_type;

   // size found by a decoder
   typedef struct packed {
      logic     hit;
      kind_type kind;
      dim_type  width;
      dim_type  height;
   } hit_type;

endpackage

`default_nettype wire

>>> design/ihds_hdr.sv
// ----------------------------------------------------------------------------
// ihds_hdr
// header byte store with png and webp size decoding
// ----------------------------------------------------------------------------
`default_nettype none

module ihds_hdr (
   input  wire logic               clock,
   input  wire ihds_pkg::step_type step,
   output      ihds_pkg::hit_type  hit,
   output      logic               jpeg_soi
);
   import ihds_pkg::*;

   logic [7:0] hdr_ff [HDR_DEPTH];
   logic [7:0] view [HDR_DEPTH];
   logic       at23;
   logic       at24;
   logic       at29;
   logic       is_png;
   logic       is_webp;
   logic [31:0] vp8l_bits;

   always_ff @(posedge clock) begin
      if (step.en && (step.pos < POSITION_BITS'(HDR_DEPTH))) begin
         hdr_ff[step.pos[4:0]] <= step.data;
      end
   end

   // the byte being written is seen at once
   always_comb begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         view[i] = (step.pos == POSITION_BITS'(i)) ? step.data : hdr_ff[i];
      end
   end

   assign at23 = (step.pos == POSITION_BITS'(23));
   assign at24 = (step.pos == POSITION_BITS'(24));
   assign at29 = (step.pos == POSITION_BITS'(29));

   assign is_png = ({view[0], view[1], view[2], view[3],
                     view[4], view[5], view[6], view[7]} == SIG_PNG) &&
                   ({view[12], view[13], view[14], view[15]} == TAG_IHDR);
   assign is_webp = ({view[0], view[1], view[2], view[3]} == TAG_RIFF) &&
                    ({view[8], view[9], view[10], view[11]} == TAG_WEBP);

   assign vp8l_bits = {view[24], view[23], view[22], view[21]};

   always_comb begin
      hit = '0;
      if (step.en && at23 && is_png) begin
         hit.hit    = 1'b1;
         hit.kind   = KIND_PNG;
         hit.width  = {view[16], view[17], view[18], view[19]};
         hit.height = {view[20], view[21], view[22], view[23]};
      end else if (step.en && at29 && is_webp &&
                   ({view[12], view[13], view[14], view[15]} == TAG_VP8X)) begin
         hit.hit    = 1'b1;
         hit.kind   = KIND_VP8X;
         hit.width  = {8'd0, view[26], view[25], view[24]} + 32'd1;
         hit.height = {8'd0, view[29], view[28], view[27]} + 32'd1;
      end else if (step.en && at29 && is_webp &&
                   ({view[12], view[13], view[14], view[15]} == TAG_VP8S)) begin
         hit.hit    = 1'b1;
         hit.kind   = KIND_VP8;
         hit.width  = {16'd0, {view[27], view[26]} & {2'b00, DIM14_MASK}};
         hit.height = {16'd0, {view[29], view[28]} & {2'b00, DIM14_MASK}};
      end else if (step.en && at24 && is_webp &&
                   ({view[12], view[13], view[14], view[15]} == TAG_VP8L)) begin
         hit.hit    = 1'b1;
         hit.kind   = KIND_VP8L;
         hit.width  = {18'd0, vp8l_bits[13:0]} + 32'd1;
         hit.height = {18'd0, vp8l_bits[27:14]} + 32'd1;
      end
   end

   // start of image seen, only looked at from byte two on
   assign jpeg_soi = (hdr_ff[0] == JPEG_FF) && (hdr_ff[1] == JPEG_SOI);

endmodule

`default_nettype wire

>>> design/ihds_jpeg.sv
// ----------------------------------------------------------------------------
// ihds_jpeg
// jpeg marker scan, segment skipping and frame header size capture
// ----------------------------------------------------------------------------
`default_nettype none

module ihds_jpeg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ihds_pkg::step_type step,
   input  wire logic               jpeg_soi,
   output      ihds_pkg::hit_type  hit
);
   import ihds_pkg::*;

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_MARKER = 3'd1;
   localparam logic [2:0] PH_LEN_HI = 3'd2;
   localparam logic [2:0] PH_LEN_LO = 3'd3;
   localparam logic [2:0] PH_SOF    = 3'd4;

   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   pos_type     next_pos_ff;
   pos_type     next_pos_in;
   logic [7:0]  len_hi_ff;
   logic [7:0]  sof_ff [4];

   logic        active;
   logic        is_sof;
   logic        is_alone;
   pos_type     pos_inc;
   pos_type     offset;
   pos_type     offset_m5;
   logic [POSITION_BITS:0] skip_sum;
   pos_type     skip_sat;

   assign active  = step.en && jpeg_soi && (step.pos >= POSITION_BITS'(2));
   assign pos_inc = step.pos + POSITION_BITS'(1);
   assign offset  = step.pos - next_pos_ff;
   assign offset_m5 = offset - POSITION_BITS'(5);

   assign is_sof = (step.data[7:4] == 4'hC) && (step.data != JPEG_DHT) &&
                   (step.data != JPEG_JPG) && (step.data != JPEG_DAC);
   assign is_alone = (step.data == JPEG_SOI) || (step.data == JPEG_TEM) ||
                     ((step.data >= JPEG_RST0) && (step.data <= JPEG_RST7));

   // marker position plus length plus two, saturating
   assign skip_sum = {1'b0, next_pos_ff} +
                     (POSITION_BITS+1)'({len_hi_ff, step.data}) +
                     (POSITION_BITS+1)'(2);
   assign skip_sat = skip_sum[POSITION_BITS] ? POS_MAX : skip_sum[POSITION_BITS-1:0];

   always_comb begin
      phase_in    = phase_ff;
      next_pos_in = next_pos_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (step.pos == next_pos_ff) begin
               if (step.data == JPEG_FF) begin
                  phase_in = PH_MARKER;
               end else begin
                  next_pos_in = pos_inc;
               end
            end
         end
         PH_MARKER: begin
            if (is_sof) begin
               phase_in = PH_SOF;
            end else if (is_alone) begin
               next_pos_in = pos_inc;
               phase_in    = PH_HUNT;
            end else begin
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            // never go back behind the current byte
            next_pos_in = (skip_sat <= step.pos) ? pos_inc : skip_sat;
            phase_in    = PH_HUNT;
         end
         PH_SOF: begin
            phase_in = PH_SOF;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || step.rearm) begin
         phase_ff    <= PH_HUNT;
         next_pos_ff <= POSITION_BITS'(2);
      end else if (active) begin
         phase_ff    <= phase_in;
         next_pos_ff <= next_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (active && (phase_ff == PH_LEN_HI)) begin
         len_hi_ff <= step.data;
      end
      if (active && (phase_ff == PH_SOF) && (offset >= POSITION_BITS'(5)) &&
          (offset <= POSITION_BITS'(8))) begin
         sof_ff[offset_m5[1:0]] <= step.data;
      end
   end

   always_comb begin
      hit = '0;
      if (active && (phase_ff == PH_SOF) && (offset == POSITION_BITS'(9))) begin
         hit.hit    = 1'b1;
         hit.kind   = KIND_JPEG;
         hit.height = {16'd0, sof_ff[0], sof_ff[1]};
         hit.width  = {16'd0, sof_ff[2], sof_ff[3]};
      end
   end

endmodule

`default_nettype wire

>>> design/image_header_dimension_parser_unit.sv
// an accepted byte goes through the input register, then the result register, to rsp
// one byte per cycle unless rsp_tready stalls it, with a single input and result register
// the byte counter, marker scan and header compares all update together on each byte
// reset (synchronous, active high) clears the pipeline valids, position and scan state
// the last byte of a file re-arms the parser in the same way
// ----------------------------------------------------------------------------
// image_header_dimension_parser_unit
// sniffs png, webp and jpeg headers from a byte stream and reports the size
// ----------------------------------------------------------------------------
`default_nettype none

module image_header_dimension_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream in
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   // size result out
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [31:0] width, [63:32] height
   output      logic [3:0]  rsp_tuser    // [0] found, [3:1] format_kind
);
   import ihds_pkg::*;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;

   // per-file state
   pos_type    pos_ff;
   logic       given_ff;

   // result register
   logic       rsp_valid_ff;
   logic       found_ff;
   kind_type   kind_ff;
   dim_type    width_ff;
   dim_type    height_ff;

   logic       out_free;
   logic       s1_go;
   logic       emit;
   step_type   step;
   hit_type    hdr_hit;
   hit_type    jpeg_hit;
   hit_type    hit;
   logic       jpeg_soi;

   // result register empties or drains this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   // a byte is looked at until a result is out or the position saturates
   assign step.en    = s1_go && !given_ff && (pos_ff != POS_MAX);
   assign step.rearm = s1_go && s1_last_ff;
   assign step.pos   = pos_ff;
   assign step.data  = s1_data_ff;

   ihds_hdr u_hdr (
      .clock    (clock),
      .step     (step),
      .hit      (hdr_hit),
      .jpeg_soi (jpeg_soi)
   );

   ihds_jpeg u_jpeg (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .jpeg_soi (jpeg_soi),
      .hit      (jpeg_hit)
   );

   // the formats exclude each other by their first bytes
   assign hit  = hdr_hit.hit ? hdr_hit : jpeg_hit;
   // a found item, or a not-found item on the last byte of the file
   assign emit = hit.hit || (s1_go && s1_last_ff && !given_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // position counts every byte of the file, stuck at its maximum
   always_ff @(posedge clock) begin
      if (reset || step.rearm) begin
         pos_ff   <= '0;
         given_ff <= 1'b0;
      end else if (s1_go) begin
         if (pos_ff != POS_MAX) begin
            pos_ff <= pos_ff + POSITION_BITS'(1);
         end
         if (hit.hit) begin
            given_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // not-found items carry zeros in every field
   always_ff @(posedge clock) begin
      if (s1_go && emit) begin
         found_ff  <= hit.hit;
         kind_ff   <= hit.hit ? hit.kind : KIND_NONE;
         width_ff  <= hit.hit ? hit.width : '0;
         height_ff <= hit.hit ? hit.height : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {height_ff, width_ff};
   assign rsp_tuser  = {kind_ff, found_ff};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams png, webp and jpeg files into the header size sniffer byte by byte
// and compares every size item with a predictor kept inside the testbench
// ----------------------------------------------------------------------------

module tb;

   import ihds_pkg::*;

   // run shape
   localparam int RANDOM_BYTES = 720;
   localparam int RANDOM_FILES = 8;       // per random phase, at least
   localparam int DRAIN_LIMIT  = 10000;   // cycles allowed for results to arrive
   localparam int TAIL_CYCLES  = 6;       // extra wait after the drain, past the block's latency

   // jpeg marker codes the stimulus needs beyond the package ones
   localparam logic [7:0] SOF_FIRST = 8'hC0;
   localparam logic [7:0] SOF_LAST  = 8'hCF;
   localparam logic [7:0] SKIP_LOW  = 8'hDB;   // first marker code above sos
   localparam logic [7:0] SKIP_HIGH = 8'hFE;

   // a riff chunk tag that no decoder knows
   localparam logic [31:0] TAG_OTHER = 32'h414C5048;

   // predictor copy of the jpeg scan phase
   typedef enum logic [2:0] {
      SCAN_HUNT,
      SCAN_MARKER,
      SCAN_LEN_HI,
      SCAN_LEN_LO,
      SCAN_SOF
   } scan_state_type;

   // stall patterns of the two sides
   typedef enum logic [1:0] {
      IDLE_RSP_HEAVY,   // sender idles at 36 percent, receiver at 60
      IDLE_REQ_HEAVY,   // sender 60, receiver 36
      IDLE_OFF          // both sides flat out
   } idle_mode_type;

   // one size item as the block reports it
   typedef struct packed {
      logic     found;
      kind_type kind;
      dim_type  width;
      dim_type  height;
   } size_rec_type;

   localparam logic [63:0] POS_LIMIT = 64'(POS_MAX);

   // ------------------------------------------------------------------------
   // clock, reset and the block's ports
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;    // [7:0] data_byte
   logic        req_tlast  = 1'b0;     // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;             // [31:0] width, [63:32] height
   logic [3:0]  rsp_tuser;             // [0] found, [3:1] format_kind

   always #4 clock = ~clock;

   image_header_dimension_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------------
   // predictor state, a private copy of the sniffer's registers
   // ------------------------------------------------------------------------
   logic [63:0]    file_pos;
   logic [7:0]     head_bytes [HDR_DEPTH];
   scan_state_type jpeg_phase;
   logic [63:0]    marker_at;
   logic [15:0]    seg_len;
   logic [7:0]     sof_dims [4];
   logic           size_done;

   // sizes predicted but not yet seen on rsp, oldest first
   size_rec_type pending_sizes [$];

   // file being built for the stimulus
   logic [7:0] file_buf [$];

   int errors      = 0;
   int bytes_sent  = 0;
   int files_sent  = 0;
   int sizes_seen  = 0;
   int misses_seen = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // back to the start state, as after reset or a last byte
   function automatic void clear_state();
      file_pos   = 64'd0;
      foreach (head_bytes[k]) head_bytes[k] = 8'h00;
      jpeg_phase = SCAN_HUNT;
      marker_at  = 64'd2;
      seg_len    = 16'h0000;
      foreach (sof_dims[k]) sof_dims[k] = 8'h00;
      size_done  = 1'b0;
   endfunction

   // position arithmetic saturates at the counter's all-ones value
   function automatic logic [63:0] pos_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > POS_LIMIT) ? POS_LIMIT : s;
   endfunction

   function automatic logic [31:0] head_be(input int at, input int n);
      logic [31:0] v;
      v = '0;
      for (int k = 0; k < n; k++) v = (v << 8) | head_bytes[at + k];
      return v;
   endfunction

   function automatic logic [31:0] head_le(input int at, input int n);
      logic [31:0] v;
      v = '0;
      for (int k = n - 1; k >= 0; k--) v = (v << 8) | head_bytes[at + k];
      return v;
   endfunction

   // looks at the byte at position p, kind stays none until a size is known
   task automatic examine_byte(input logic [63:0] p, input logic [7:0] d,
                               output kind_type kind, output dim_type w, output dim_type h);
      logic [31:0] bits;
      logic [63:0] nxt;
      logic [63:0] off;
      kind = KIND_NONE;
      w    = '0;
      h    = '0;
      if (p < HDR_DEPTH) head_bytes[int'(p)] = d;

      if (p == 23 && head_be(0, 4) == SIG_PNG[63:32] && head_be(4, 4) == SIG_PNG[31:0]
          && head_be(12, 4) == TAG_IHDR) begin
         kind = KIND_PNG;
         w    = head_be(16, 4);
         h    = head_be(20, 4);
      end else if ((p == 24 || p == 29) && head_be(0, 4) == TAG_RIFF
                   && head_be(8, 4) == TAG_WEBP) begin
         // riff/webp never falls through to the jpeg scan at these offsets
         if (p == 29 && head_be(12, 4) == TAG_VP8X) begin
            kind = KIND_VP8X;
            w    = head_le(24, 3) + 32'd1;
            h    = head_le(27, 3) + 32'd1;
         end else if (p == 29 && head_be(12, 4) == TAG_VP8S) begin
            kind = KIND_VP8;
            w    = head_le(26, 2) & {18'h0, DIM14_MASK};
            h    = head_le(28, 2) & {18'h0, DIM14_MASK};
         end else if (p == 24 && head_be(12, 4) == TAG_VP8L) begin
            bits = head_le(21, 4);
            kind = KIND_VP8L;
            w    = {18'h0, bits[13:0]} + 32'd1;
            h    = {18'h0, bits[27:14]} + 32'd1;
         end
      end else if (p >= 2 && head_bytes[0] == JPEG_FF && head_bytes[1] == JPEG_SOI) begin
         case (jpeg_phase)
            SCAN_HUNT: begin
               if (p == marker_at) begin
                  if (d == JPEG_FF) jpeg_phase = SCAN_MARKER;
                  else marker_at = pos_add(p, 64'd1);
               end
            end
            SCAN_MARKER: begin
               if (d >= SOF_FIRST && d <= SOF_LAST && d != JPEG_DHT && d != JPEG_JPG
                   && d != JPEG_DAC) begin
                  jpeg_phase = SCAN_SOF;
               end else if (d == JPEG_SOI || d == JPEG_TEM
                            || (d >= JPEG_RST0 && d <= JPEG_RST7)) begin
                  marker_at  = pos_add(p, 64'd1);
                  jpeg_phase = SCAN_HUNT;
               end else begin
                  jpeg_phase = SCAN_LEN_HI;
               end
            end
            SCAN_LEN_HI: begin
               seg_len    = {d, 8'h00};
               jpeg_phase = SCAN_LEN_LO;
            end
            SCAN_LEN_LO: begin
               seg_len[7:0] = d;
               nxt = pos_add(marker_at, 64'(seg_len) + 64'd2);
               // tiny lengths never move the scan backwards
               if (nxt < p + 64'd1) nxt = pos_add(p, 64'd1);
               marker_at  = nxt;
               jpeg_phase = SCAN_HUNT;
            end
            SCAN_SOF: begin
               off = p - marker_at;
               if (off >= 5 && off <= 8) begin
                  sof_dims[int'(off - 5)] = d;
               end else if (off == 9) begin
                  kind = KIND_JPEG;
                  h    = {16'h0, sof_dims[0], sof_dims[1]};
                  w    = {16'h0, sof_dims[2], sof_dims[3]};
               end
            end
            default: jpeg_phase = SCAN_HUNT;
         endcase
      end
   endtask

   // predicts what one accepted byte causes on rsp
   task automatic sniff_byte(input logic [7:0] d, input logic last);
      kind_type     kind;
      dim_type      w;
      dim_type      h;
      size_rec_type rec;
      if (!size_done && file_pos < POS_LIMIT) begin
         examine_byte(file_pos, d, kind, w, h);
         if (kind != KIND_NONE) begin
            rec.found  = 1'b1;
            rec.kind   = kind;
            rec.width  = w;
            rec.height = h;
            pending_sizes.insert(pending_sizes.size(), rec);
            size_done = 1'b1;
         end
      end
      if (file_pos < POS_LIMIT) file_pos++;
      if (last) begin
         if (!size_done) begin
            rec = '0;
            pending_sizes.insert(pending_sizes.size(), rec);
         end
         clear_state();
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: random back-pressure and field by field comparison
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_size_item();
      size_rec_type want;
      if (rsp_tuser[0]) sizes_seen++;
      else misses_seen++;
      if (pending_sizes.size() == 0) begin
         errors++;
         $display("%0t unexpected result item: expected none, actual tuser %h tdata %h",
                  $time, rsp_tuser, rsp_tdata);
      end else begin
         want = pending_sizes.pop_front();
         check_field("found",       32'(want.found), 32'(rsp_tuser[0]));
         check_field("format_kind", 32'(want.kind),  32'(rsp_tuser[3:1]));
         check_field("width",       want.width,      rsp_tdata[31:0]);
         check_field("height",      want.height,     rsp_tdata[63:32]);
      end
   endtask

   // samples happen on the edge before any of this step's updates land
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_size_item();
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // byte stream side
   // ------------------------------------------------------------------------

   // valid stays high across back to back items, it only drops for an idle cycle
   task automatic send_byte(input logic [7:0] d, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sniff_byte(d, last);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_buf[k]) send_byte(file_buf[k], k == file_buf.size() - 1);
      files_sent++;
   endtask

   // holds the stream until every predicted size has come out or the drain limit is reached
   task automatic await_sizes();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_sizes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_RSP_HEAVY: begin req_idle_pct = 36; rsp_idle_pct = 60; end
         IDLE_REQ_HEAVY: begin req_idle_pct = 60; rsp_idle_pct = 36; end
         default:        begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // file builders
   // ------------------------------------------------------------------------

   // extremes turn up far more often than a flat draw would give them
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [31:0] rand_dim();
      case ($urandom_range(3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_be(input logic [63:0] v, input int n);
      for (int k = n - 1; k >= 0; k--) file_buf.insert(file_buf.size(), v[8*k +: 8]);
   endtask

   task automatic add_rand(input int n);
      repeat (n) file_buf.insert(file_buf.size(), rand_byte());
   endtask

   // overwrites n bytes at an offset, first byte taken from the top
   task automatic set_be(input int at, input logic [31:0] v, input int n);
      for (int k = 0; k < n; k++) file_buf[at + k] = v[8*(n-1-k) +: 8];
   endtask

   // signature, chunk length and ihdr tag, the rest random up to len bytes
   task automatic build_png(input int len);
      file_buf.delete();
      add_be(SIG_PNG, 8);
      add_rand(4);
      add_be(64'(TAG_IHDR), 4);
      add_rand(len - 16);
   endtask

   // riff size, webp, then the given chunk tag and random bytes up to len
   task automatic build_webp(input logic [31:0] tag, input int len);
      file_buf.delete();
      add_be(64'(TAG_RIFF), 4);
      add_rand(4);
      add_be(64'(TAG_WEBP), 4);
      add_be(64'(tag), 4);
      add_rand(len - 16);
   endtask

   function automatic logic [7:0] standalone_code();
      case ($urandom_range(2))
         0:       return JPEG_SOI;
         1:       return JPEG_TEM;
         default: return 8'(JPEG_RST0 + $urandom_range(7));
      endcase
   endfunction

   function automatic logic [7:0] skip_code();
      case ($urandom_range(3))
         0:       return JPEG_DHT;
         1:       return JPEG_JPG;
         2:       return JPEG_DAC;
         default: return 8'($urandom_range(SKIP_LOW, SKIP_HIGH));
      endcase
   endfunction

   function automatic logic [7:0] sof_code();
      logic [7:0] c;
      do c = 8'($urandom_range(SOF_FIRST, SOF_LAST));
      while (c == JPEG_DHT || c == JPEG_JPG || c == JPEG_DAC);
      return c;
   endfunction

   // soi, a few standalone markers, fill bytes and skipped segments, then a sof
   task automatic build_jpeg();
      int len;
      file_buf.delete();
      add_be(64'({JPEG_FF, JPEG_SOI}), 2);
      repeat ($urandom_range(4)) begin
         case ($urandom_range(3))
            0: add_be(64'({JPEG_FF, standalone_code()}), 2);
            1: repeat ($urandom_range(1, 3))
                  file_buf.insert(file_buf.size(), 8'($urandom_range(8'hFE)));
            default: begin
               len = ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
               // now and then a long segment runs past the end of the file
               if ($urandom_range(15) == 0) len += 256 * $urandom_range(1, 255);
               add_be(64'({JPEG_FF, skip_code(), 16'(len)}), 4);
               add_rand((len >= 2 && len < 256) ? len - 2 : 0);
            end
         endcase
      end
      add_be(64'({JPEG_FF, sof_code(), 16'h0011, 8'h08}), 5);
      add_rand(4 + 1 + $urandom_range(6));
   endtask

   task automatic build_random_file();
      int pick;
      int cut;
      int idx;
      pick = $urandom_range(9);
      case (pick)
         0, 1: begin
            build_png(24 + $urandom_range(8));
            set_be(16, rand_dim(), 4);
            set_be(20, rand_dim(), 4);
         end
         2: build_webp(TAG_VP8X, 30 + $urandom_range(6));
         3: build_webp(TAG_VP8S, 30 + $urandom_range(6));
         4: build_webp(($urandom_range(7) == 0) ? TAG_OTHER : TAG_VP8L, 25 + $urandom_range(6));
         5, 6, 7: build_jpeg();
         8: begin
            // noise, sometimes behind the start of a real signature
            file_buf.delete();
            case ($urandom_range(3))
               0: add_be(64'({JPEG_FF, JPEG_SOI}), 2);
               1: add_be(64'(TAG_RIFF), 4);
               2: add_be(64'(SIG_PNG[63:32]), 4);
               default: ;
            endcase
            add_rand($urandom_range(1, 40));
         end
         default: begin
            file_buf.delete();
            add_rand($urandom_range(1, 3));
         end
      endcase
      // broken sequences: a flipped byte or a file cut short
      if (pick < 8 && $urandom_range(7) == 0) begin
         idx = $urandom_range(file_buf.size() - 1);
         file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
      end
      if (pick < 8 && $urandom_range(7) == 0) begin
         cut = $urandom_range(1, file_buf.size());
         while (file_buf.size() > cut) file_buf.delete(file_buf.size() - 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_png_headers();
      // widest width, zero height, crc and a tail after the size
      build_png(30);
      set_be(16, 32'hFFFF_FFFF, 4);
      set_be(20, 32'h0000_0000, 4);
      send_file();
      // size completes on the very last byte
      build_png(24);
      set_be(16, 32'h0000_0000, 4);
      set_be(20, 32'hFFFF_FFFF, 4);
      send_file();
      // one byte short of the height
      build_png(23);
      send_file();
      // wrong chunk tag behind a good signature
      build_png(30);
      file_buf[15] = 8'h78;
      send_file();
   endtask

   task automatic test_webp_headers();
      // vp8x at both ends of the 24-bit range, plus one
      build_webp(TAG_VP8X, 34);
      set_be(24, 32'h00FF_FFFF, 3);
      set_be(27, 32'h0000_0000, 3);
      send_file();
      // lossy vp8, only 14 bits of each dimension survive
      build_webp(TAG_VP8S, 30);
      set_be(26, 32'h0000_FFFF, 2);
      set_be(28, 32'h0000_00C0, 2);
      send_file();
      // lossless vp8l, all ones then all zeros in the packed size word
      build_webp(TAG_VP8L, 25);
      set_be(21, 32'hFFFF_FFFF, 4);
      send_file();
      build_webp(TAG_VP8L, 28);
      set_be(21, 32'h0000_0000, 4);
      send_file();
      // unknown chunk tag is not recognised
      build_webp(TAG_OTHER, 30);
      send_file();
      // vp8x that ends before its last size byte
      build_webp(TAG_VP8X, 29);
      send_file();
   endtask

   task automatic test_jpeg_markers();
      // standalone markers, fill bytes, tiny lengths, excluded codes, then sof0
      file_buf.delete();
      add_be({JPEG_FF, JPEG_SOI, JPEG_FF, JPEG_SOI, JPEG_FF, JPEG_TEM, JPEG_FF, JPEG_RST0}, 8);
      add_be(64'({JPEG_FF, JPEG_RST7, 8'h00, 8'h5A}), 4);
      add_be(64'hFFE0_0000_FFE1_0001, 8);
      add_be(64'({JPEG_FF, JPEG_DHT, 32'h0004_1122}), 6);
      add_be(64'({JPEG_FF, JPEG_JPG, 16'h0002}), 4);
      add_be(64'({JPEG_FF, JPEG_DAC, 24'h00_0333}), 5);
      add_be(64'({JPEG_FF, SOF_FIRST, 16'h0011, 8'h08}), 5);
      add_be(64'h00FF_FF00_0003, 5);
      add_rand(4);
      send_file();
      // sof whose ninth byte never comes
      file_buf.delete();
      add_be({JPEG_FF, JPEG_SOI, JPEG_FF, 8'hC2, 32'h0011_0812}, 8);
      add_be(64'h0034_5678, 3);
      send_file();
      // sof completed by the last byte
      file_buf.delete();
      add_be({JPEG_FF, JPEG_SOI, JPEG_FF, SOF_LAST, 32'h0011_0800}, 8);
      add_be(64'h00FF_FF01, 4);
      send_file();
      // no start of image, the same sof is never looked at
      file_buf.delete();
      add_be({JPEG_FF, 8'hD9, JPEG_FF, SOF_FIRST, 32'h0011_0812}, 8);
      add_be(64'h3456_789A, 4);
      send_file();
   endtask

   task automatic test_short_files();
      file_buf.delete();
      add_be(64'h00, 1);
      send_file();
      file_buf.delete();
      add_be(64'hFF, 1);
      send_file();
      file_buf.delete();
      add_be(64'({JPEG_FF, JPEG_SOI}), 2);
      send_file();
   endtask

   // the stream stops until the pipeline is empty, then carries on
   task automatic test_pause_until_drained();
      build_png(26);
      send_file();
      await_sizes();
      build_jpeg();
      send_file();
      await_sizes();
   endtask

   task automatic test_random_files(input int byte_goal, input int file_goal);
      int bytes_start;
      int files_start;
      bytes_start = bytes_sent;
      files_start = files_sent;
      while (bytes_sent - bytes_start < byte_goal || files_sent - files_start < file_goal) begin
         build_random_file();
         send_file();
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      clear_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(IDLE_RSP_HEAVY);
      test_png_headers();
      test_webp_headers();
      test_jpeg_markers();
      test_short_files();
      test_pause_until_drained();
      test_random_files(RANDOM_BYTES / 3, RANDOM_FILES);

      set_idling(IDLE_REQ_HEAVY);
      test_random_files(RANDOM_BYTES / 3, RANDOM_FILES);

      set_idling(IDLE_OFF);
      test_random_files(RANDOM_BYTES / 3, RANDOM_FILES);

      // let the last items drain out
      await_sizes();
      if (pending_sizes.size() != 0) begin
         errors += pending_sizes.size();
         $display("%0t %0d expected result items never arrived", $time, pending_sizes.size());
      end

      $display("streamed %0d files in %0d bytes: %0d sizes reported, %0d not recognised",
               files_sent, bytes_sent, sizes_seen, misses_seen);
      $display("png, webp vp8x/vp8/vp8l and jpeg marker scans, cut and corrupted files, "
               , "three stall patterns");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // guard against a hung handshake, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
design/ihds_pkg.sv
design/ihds_hdr.sv
design/ihds_jpeg.sv
design/image_header_dimension_parser_unit.sv
tb/sv/tb.sv
